/* design/giou_pkg.sv */
// Package for the greedy IoU track association unit.
// Sizes, register indexes and the box record shared by the design files.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package giou_pkg;

  localparam int MAX_TRACKS     = 32;
  localparam int MAX_DETECTIONS = 32;
  localparam int COORD_BITS     = 12;

  localparam int SLOT_W   = $clog2(MAX_TRACKS);
  localparam int SCAN_W   = $clog2(MAX_TRACKS + 1);
  localparam int DET_W    = $clog2(MAX_DETECTIONS);
  localparam int DCNT_W   = $clog2(MAX_DETECTIONS + 1);
  localparam int ID_W     = 16;
  localparam int KEY_W    = ID_W + SLOT_W;
  localparam int AREA_W   = 2 * (COORD_BITS + 1);
  localparam int PROD_W   = 2 * AREA_W;
  localparam int CEN_W    = COORD_BITS + 2;
  localparam int DVD_W    = CEN_W + 10;
  localparam int BITC_W   = $clog2(DVD_W + 1);

  localparam logic [1:0] REG_IOU_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_MAX_LOST      = 2'd1;
  localparam logic [1:0] REG_TIMEOUT       = 2'd2;

  localparam logic [15:0] IOU_THRESHOLD_RST = 16'd19661;
  localparam logic [7:0]  MAX_LOST_RST      = 8'd30;
  localparam logic [15:0] TIMEOUT_RST       = 16'd5000;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] h;
  } box_t;

endpackage

`default_nettype wire

/* design/greedy_iou_track_association_unit.sv */
// Detection requests are taken while idle. End of frame runs a sequencer:
// ordering scans over the track slots, an IoU test per track/detection pair,
// divider and write-back per matched track, an expiry sweep, then an
// ordering scan plus load and handshake per result. Throughput is one
// request at a time; the shared 26x26 multiplier and radix-2 divider set it.
// Reset: synchronous, clears the track table and buffer, restores config defaults.
`timescale 1ns / 1ps
`default_nettype none

module greedy_iou_track_association_unit
  import giou_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  req_valid,
  output logic                       req_ready,
  input  wire logic                  action,
  input  wire logic [COORD_BITS-1:0] box_x,
  input  wire logic [COORD_BITS-1:0] box_y,
  input  wire logic [COORD_BITS-1:0] box_w,
  input  wire logic [COORD_BITS-1:0] box_h,
  input  wire logic [31:0]           frame_time,
  output logic                       res_valid,
  input  wire logic                  res_ready,
  output logic                       track_valid,
  output logic [ID_W-1:0]            trk_id,
  output logic [COORD_BITS-1:0]      out_x,
  output logic [COORD_BITS-1:0]      out_y,
  output logic [COORD_BITS-1:0]      out_w,
  output logic [COORD_BITS-1:0]      out_h,
  output logic signed [15:0]         vel_x,
  output logic signed [15:0]         vel_y,
  output logic [7:0]                 lost_count,
  output logic                       dropped,
  output logic                       last,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [15:0]           cfg_data
);

  typedef enum logic [16:0] {
    S_IDLE = 17'h00001, S_SCAN = 17'h00002, S_DET  = 17'h00004,
    S_MIN  = 17'h00008, S_MAA  = 17'h00010, S_MAB  = 17'h00020,
    S_UNI  = 17'h00040, S_MTH  = 17'h00080, S_MC1  = 17'h00100,
    S_MC2  = 17'h00200, S_TRK  = 17'h00400, S_DIV  = 17'h00800,
    S_WR   = 17'h01000, S_NEW  = 17'h02000, S_SWP  = 17'h04000,
    S_LOAD = 17'h08000, S_OUT  = 17'h10000
  } state_t;

  state_t state;

  logic [15:0] iou_thr;
  logic [7:0]  max_lost;
  logic [15:0] timeout;

  box_t                    det_buf [MAX_DETECTIONS];
  logic [DCNT_W-1:0]       det_count;
  logic [MAX_DETECTIONS-1:0] det_taken;
  logic [MAX_TRACKS-1:0]   slot_valid;
  logic [ID_W-1:0]         slot_id [MAX_TRACKS];
  box_t                    slot_box [MAX_TRACKS];
  logic [7:0]              slot_lost [MAX_TRACKS];
  logic [31:0]             slot_seen [MAX_TRACKS];
  logic signed [15:0]      slot_vx [MAX_TRACKS];
  logic signed [15:0]      slot_vy [MAX_TRACKS];
  logic [ID_W-1:0]         next_id;
  logic                    overflow;

  logic [31:0]       now;
  logic              emit_mode;
  logic [SCAN_W-1:0] scan_s;
  logic              have_prev;
  logic              fnd;
  logic [KEY_W-1:0]  prev_key;
  logic [KEY_W-1:0]  best_key;
  logic [SLOT_W-1:0] t;
  logic [SLOT_W-1:0] pend;
  logic              pend_has;
  logic [DCNT_W-1:0] di;
  logic [SCAN_W-1:0] ns;
  logic              best_found;
  logic [DET_W-1:0]  best_i;
  logic [AREA_W-1:0] bi, bu;
  logic [COORD_BITS:0] iw, ih;
  logic [AREA_W-1:0] inter, aa, ab, un;
  logic [PROD_W-1:0] p1;
  logic [31:0]       dt;
  logic              dt_zero;
  logic [DVD_W-1:0]  dvd;
  logic [32:0]       rem;
  logic [DVD_W-1:0]  q;
  logic [BITC_W-1:0] bitc;
  logic              vsel;
  logic              neg;
  logic signed [15:0] vx_new, vy_new;

  logic [SLOT_W-1:0] sra;
  logic [DET_W-1:0]  dra;
  box_t              sb, db;
  logic [COORD_BITS-1:0] x1, y1;
  logic [COORD_BITS:0]   ax2, bx2, ay2, by2, x2, y2;
  logic              ovl;
  logic [AREA_W-1:0] mul_a, mul_b;
  logic [PROD_W-1:0] prod;
  logic [KEY_W-1:0]  key;
  logic [CEN_W-1:0]  cxo, cxn, cyo, cyn;
  logic [CEN_W-1:0]  adx, ady;
  logic [DVD_W-1:0]  magx, magy;
  logic [32:0]       sh;
  logic [31:0]       dt_c;
  logic [31:0]       age;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    unique case (state)
      S_SCAN, S_SWP: sra = scan_s[SLOT_W-1:0];
      S_NEW:         sra = ns[SLOT_W-1:0];
      S_LOAD:        sra = pend;
      default:       sra = t;
    endcase
  end

  assign dra = (state == S_TRK || state == S_DIV || state == S_WR) ? best_i : di[DET_W-1:0];
  assign sb  = slot_box[sra];
  assign db  = det_buf[dra];

  assign x1  = (sb.x > db.x) ? sb.x : db.x;
  assign y1  = (sb.y > db.y) ? sb.y : db.y;
  assign ax2 = {1'b0, sb.x} + {1'b0, sb.w};
  assign bx2 = {1'b0, db.x} + {1'b0, db.w};
  assign ay2 = {1'b0, sb.y} + {1'b0, sb.h};
  assign by2 = {1'b0, db.y} + {1'b0, db.h};
  assign x2  = (ax2 < bx2) ? ax2 : bx2;
  assign y2  = (ay2 < by2) ? ay2 : by2;
  assign ovl = (x2 > {1'b0, x1}) && (y2 > {1'b0, y1});

  always_comb begin
    unique case (state)
      S_MIN: begin
        mul_a = AREA_W'(iw);
        mul_b = AREA_W'(ih);
      end
      S_MAA: begin
        mul_a = AREA_W'(sb.w);
        mul_b = AREA_W'(sb.h);
      end
      S_MAB: begin
        mul_a = AREA_W'(db.w);
        mul_b = AREA_W'(db.h);
      end
      S_MTH: begin
        mul_a = AREA_W'(iou_thr);
        mul_b = un;
      end
      S_MC1: begin
        mul_a = inter;
        mul_b = bu;
      end
      default: begin
        mul_a = bi;
        mul_b = un;
      end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign key  = {slot_id[sra], sra};

  assign cxo  = {1'b0, sb.x, 1'b0} + CEN_W'(sb.w);
  assign cxn  = {1'b0, db.x, 1'b0} + CEN_W'(db.w);
  assign cyo  = {1'b0, sb.y, 1'b0} + CEN_W'(sb.h);
  assign cyn  = {1'b0, db.y, 1'b0} + CEN_W'(db.h);
  assign adx  = (cxn >= cxo) ? cxn - cxo : cxo - cxn;
  assign ady  = (cyn >= cyo) ? cyn - cyo : cyo - cyn;
  assign magx = DVD_W'(adx) * DVD_W'(500);
  assign magy = DVD_W'(ady) * DVD_W'(500);
  assign sh   = {rem[31:0], dvd[DVD_W-1]};
  assign dt_c = now - slot_seen[t];
  assign age  = now - slot_seen[sra];

  function automatic logic signed [15:0] sat_vel(input logic [DVD_W-1:0] qv, input logic n);
    logic signed [15:0] r;
    if (!n) begin
      r = (qv > DVD_W'(32767)) ? 16'sh7fff : 16'(qv);
    end else begin
      r = (qv > DVD_W'(32768)) ? 16'sh8000 : -16'(qv);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      iou_thr    <= IOU_THRESHOLD_RST;
      max_lost   <= MAX_LOST_RST;
      timeout    <= TIMEOUT_RST;
      det_count  <= '0;
      det_taken  <= '0;
      slot_valid <= '0;
      next_id    <= ID_W'(1);
      overflow   <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_IOU_THRESHOLD: iou_thr  <= cfg_data;
          REG_MAX_LOST:      max_lost <= cfg_data[7:0];
          REG_TIMEOUT:       timeout  <= cfg_data;
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            if (!action) begin
              if (det_count < DCNT_W'(MAX_DETECTIONS)) begin
                det_buf[det_count[DET_W-1:0]] <= '{box_x, box_y, box_w, box_h};
                det_count <= det_count + 1'b1;
              end else begin
                overflow <= 1'b1;
              end
            end else begin
              now       <= frame_time;
              emit_mode <= 1'b0;
              have_prev <= 1'b0;
              scan_s    <= '0;
              fnd       <= 1'b0;
              state     <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          if (scan_s != SCAN_W'(MAX_TRACKS)) begin
            if (slot_valid[sra] && (!have_prev || key > prev_key) && (!fnd || key < best_key)) begin
              best_key <= key;
              fnd      <= 1'b1;
            end
            scan_s <= scan_s + 1'b1;
          end else begin
            if (fnd) begin
              prev_key  <= best_key;
              have_prev <= 1'b1;
            end
            if (!emit_mode) begin
              di <= '0;
              if (fnd) begin
                t          <= best_key[SLOT_W-1:0];
                best_found <= 1'b0;
                state      <= S_DET;
              end else begin
                ns    <= '0;
                state <= S_NEW;
              end
            end else if (pend_has) begin
              state <= S_LOAD;
            end else if (fnd) begin
              pend     <= best_key[SLOT_W-1:0];
              pend_has <= 1'b1;
              scan_s   <= '0;
              fnd      <= 1'b0;
            end else begin
              track_valid <= 1'b0;
              trk_id      <= '0;
              out_x       <= '0;
              out_y       <= '0;
              out_w       <= '0;
              out_h       <= '0;
              vel_x       <= '0;
              vel_y       <= '0;
              lost_count  <= '0;
              dropped     <= overflow;
              last        <= 1'b1;
              res_valid   <= 1'b1;
              state       <= S_OUT;
            end
          end
        end

        S_DET: begin
          if (di >= det_count) begin
            state <= S_TRK;
          end else if (det_taken[dra] || !ovl) begin
            di <= di + 1'b1;
          end else begin
            iw    <= x2 - {1'b0, x1};
            ih    <= y2 - {1'b0, y1};
            state <= S_MIN;
          end
        end

        S_MIN: begin
          inter <= prod[AREA_W-1:0];
          state <= S_MAA;
        end

        S_MAA: begin
          aa    <= prod[AREA_W-1:0];
          state <= S_MAB;
        end

        S_MAB: begin
          ab    <= prod[AREA_W-1:0];
          state <= S_UNI;
        end

        S_UNI: begin
          un    <= aa + ab - inter;
          state <= S_MTH;
        end

        S_MTH: begin
          if ({(PROD_W-AREA_W-16)'(0), inter, 16'd0} <= prod) begin
            di    <= di + 1'b1;
            state <= S_DET;
          end else if (!best_found) begin
            best_found <= 1'b1;
            best_i     <= dra;
            bi         <= inter;
            bu         <= un;
            di         <= di + 1'b1;
            state      <= S_DET;
          end else begin
            state <= S_MC1;
          end
        end

        S_MC1: begin
          p1    <= prod;
          state <= S_MC2;
        end

        S_MC2: begin
          if (p1 > prod) begin
            best_i <= dra;
            bi     <= inter;
            bu     <= un;
          end
          di    <= di + 1'b1;
          state <= S_DET;
        end

        S_TRK: begin
          if (best_found) begin
            dt      <= dt_c;
            dt_zero <= (dt_c == 32'd0);
            if (dt_c == 32'd0) begin
              state <= S_WR;
            end else begin
              dvd   <= magx;
              neg   <= (cxn < cxo);
              rem   <= '0;
              q     <= '0;
              bitc  <= '0;
              vsel  <= 1'b0;
              state <= S_DIV;
            end
          end else begin
            if (slot_lost[t] != 8'hff) slot_lost[t] <= slot_lost[t] + 1'b1;
            scan_s <= '0;
            fnd    <= 1'b0;
            state  <= S_SCAN;
          end
        end

        S_DIV: begin
          if (bitc != BITC_W'(DVD_W)) begin
            if (sh >= {1'b0, dt}) begin
              rem <= sh - {1'b0, dt};
              q   <= {q[DVD_W-2:0], 1'b1};
            end else begin
              rem <= sh;
              q   <= {q[DVD_W-2:0], 1'b0};
            end
            dvd  <= {dvd[DVD_W-2:0], 1'b0};
            bitc <= bitc + 1'b1;
          end else if (!vsel) begin
            vx_new <= sat_vel(q, neg);
            dvd    <= magy;
            neg    <= (cyn < cyo);
            rem    <= '0;
            q      <= '0;
            bitc   <= '0;
            vsel   <= 1'b1;
          end else begin
            vy_new <= sat_vel(q, neg);
            state  <= S_WR;
          end
        end

        S_WR: begin
          if (!dt_zero) begin
            slot_vx[t] <= vx_new;
            slot_vy[t] <= vy_new;
          end
          slot_box[t]       <= db;
          slot_lost[t]      <= '0;
          slot_seen[t]      <= now;
          det_taken[best_i] <= 1'b1;
          scan_s            <= '0;
          fnd               <= 1'b0;
          state             <= S_SCAN;
        end

        S_NEW: begin
          if (di >= det_count) begin
            scan_s <= '0;
            state  <= S_SWP;
          end else if (det_taken[dra]) begin
            di <= di + 1'b1;
          end else if (ns == SCAN_W'(MAX_TRACKS)) begin
            overflow <= 1'b1;
            di       <= di + 1'b1;
          end else if (slot_valid[sra]) begin
            ns <= ns + 1'b1;
          end else begin
            slot_valid[sra] <= 1'b1;
            slot_id[sra]    <= next_id;
            slot_box[sra]   <= db;
            slot_lost[sra]  <= '0;
            slot_seen[sra]  <= now;
            slot_vx[sra]    <= '0;
            slot_vy[sra]    <= '0;
            next_id         <= (next_id == {ID_W{1'b1}}) ? ID_W'(1) : next_id + 1'b1;
            di              <= di + 1'b1;
          end
        end

        S_SWP: begin
          if (scan_s != SCAN_W'(MAX_TRACKS)) begin
            if (slot_valid[sra] && (slot_lost[sra] > max_lost || age > {16'd0, timeout}))
              slot_valid[sra] <= 1'b0;
            scan_s <= scan_s + 1'b1;
          end else begin
            emit_mode <= 1'b1;
            have_prev <= 1'b0;
            pend_has  <= 1'b0;
            scan_s    <= '0;
            fnd       <= 1'b0;
            state     <= S_SCAN;
          end
        end

        S_LOAD: begin
          track_valid <= 1'b1;
          trk_id      <= slot_id[sra];
          out_x       <= sb.x;
          out_y       <= sb.y;
          out_w       <= sb.w;
          out_h       <= sb.h;
          vel_x       <= slot_vx[sra];
          vel_y       <= slot_vy[sra];
          lost_count  <= slot_lost[sra];
          dropped     <= overflow;
          last        <= !fnd;
          res_valid   <= 1'b1;
          state       <= S_OUT;
        end

        S_OUT: begin
          if (res_ready) begin
            res_valid <= 1'b0;
            if (last) begin
              det_count <= '0;
              det_taken <= '0;
              overflow  <= 1'b0;
              state     <= S_IDLE;
            end else begin
              pend   <= best_key[SLOT_W-1:0];
              scan_s <= '0;
              fnd    <= 1'b0;
              state  <= S_SCAN;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/giou_checker.sv */
// Port-level checks for the greedy IoU track association unit.
// Bound to greedy_iou_track_association_unit; uses giou_pkg widths.
`timescale 1ns / 1ps
`default_nettype none

module giou_checker
  import giou_pkg::*;
(
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            req_ready,
  input wire logic            res_valid,
  input wire logic            res_ready,
  input wire logic            track_valid,
  input wire logic [ID_W-1:0] trk_id,
  input wire logic            last
);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(req_ready && res_valid)) else $error("request taken while result pending");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(trk_id))
    else $error("stalled result changed");

  a_busy_mid_frame: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && !last |=> !req_ready)
    else $error("ready before final result");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && !track_valid |-> last) else $error("empty result not final");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> req_ready && !res_valid) else $error("not idle after reset");

endmodule

bind greedy_iou_track_association_unit giou_checker u_giou_checker (
  .clk(clk), .rst(rst), .req_ready(req_ready), .res_valid(res_valid),
  .res_ready(res_ready), .track_valid(track_valid), .trk_id(trk_id), .last(last)
);

`default_nettype wire
